>>> hw/rtl/sqmm_pkg.sv
// Shared types and constants for the square matrix multiply block.
package sqmm_pkg;

  localparam int ELEM_W = 16;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W  = 38;
  localparam int IDX_PORT_W = 4;

  localparam logic [1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } sqmm_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic issue;
    logic k_first;
    logic k_last;
  } sqmm_ctl_t;

endpackage

>>> hw/rtl/sqmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sqmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/sqmm_ctrl.sv
// Controller state machine: command decode and the row/column/term counters.
module sqmm_ctrl #(
  parameter int SIZE = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_command,
  input  logic [sqmm_pkg::IDX_PORT_W-1:0]    in_row,
  input  logic [sqmm_pkg::IDX_PORT_W-1:0]    in_col,
  output sqmm_pkg::sqmm_ctl_t                ctl,
  output logic [sqmm_pkg::IDX_PORT_W-1:0]    ctl_row,
  output logic [$clog2(SIZE)-1:0]            ctl_j,
  output logic [$clog2(SIZE)-1:0]            ctl_k
);
  import sqmm_pkg::*;

  localparam int IDX_W = $clog2(SIZE);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SIZE - 1);

  sqmm_state_t           state_r, state_nxt;
  logic                  flush_r, flush_nxt;
  logic [IDX_PORT_W-1:0] row_r, row_nxt;
  logic [IDX_W-1:0]      j_r, j_nxt;
  logic [IDX_W-1:0]      k_r, k_nxt;
  logic                  accept;
  logic                  row_ok;
  logic                  col_ok;

  assign accept = start && !busy;
  assign row_ok = 32'(in_row) < 32'(SIZE);
  assign col_ok = 32'(in_col) < 32'(SIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      flush_r <= 1'b0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      flush_r <= flush_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    flush_nxt   = flush_r;
    row_nxt     = row_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    busy        = 1'b1;
    ctl         = '0;
    ctl.k_first = (k_r == '0);
    ctl.k_last  = (k_r == IDX_LAST);
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (accept) begin
          ctl.wr_a = (in_command == CMD_LOAD_A) && row_ok && col_ok;
          ctl.wr_b = (in_command == CMD_LOAD_B) && row_ok && col_ok;
          if ((in_command == CMD_COMPUTE) && row_ok) begin
            row_nxt   = in_row;
            j_nxt     = '0;
            k_nxt     = '0;
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        ctl.issue = 1'b1;
        if (k_r == IDX_LAST) begin
          k_nxt = '0;
          if (j_r == IDX_LAST) begin
            j_nxt     = '0;
            flush_nxt = 1'b0;
            state_nxt = ST_FLUSH;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_FLUSH: begin
        // Waiting here until flush_r is set lets the last term pass the read and multiply stages.
        flush_nxt = 1'b1;
        if (flush_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign ctl_row = row_r;
  assign ctl_j   = j_r;
  assign ctl_k   = k_r;

  a_issue_runs: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.issue && !ctl.k_last |=> ctl.issue)
    else $error("term issue stopped inside a dot product");

  a_drain_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    busy && !ctl.issue |=> !ctl.issue)
    else $error("term issued while draining");

  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && in_command == CMD_COMPUTE))
    else $error("busy rose without an accepted compute item");

endmodule

>>> hw/rtl/sqmm_datapath.sv
// Datapath: the two matrix stores, the shared multiply-accumulate and result registers.
module sqmm_datapath #(
  parameter int SIZE = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sqmm_pkg::sqmm_ctl_t                ctl,
  input  logic [sqmm_pkg::IDX_PORT_W-1:0]    ctl_row,
  input  logic [$clog2(SIZE)-1:0]            ctl_j,
  input  logic [$clog2(SIZE)-1:0]            ctl_k,
  input  logic [sqmm_pkg::IDX_PORT_W-1:0]    in_row,
  input  logic [sqmm_pkg::IDX_PORT_W-1:0]    in_col,
  input  logic signed [sqmm_pkg::ELEM_W-1:0] in_element,
  output logic                               out_valid,
  output logic [sqmm_pkg::IDX_PORT_W-1:0]    out_row,
  output logic [sqmm_pkg::IDX_PORT_W-1:0]    out_col,
  output logic signed [sqmm_pkg::ACC_W-1:0]  out_product_value,
  output logic                               out_last
);
  import sqmm_pkg::*;

  localparam int IDX_W = $clog2(SIZE);
  localparam int DEPTH = SIZE * SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SIZE - 1);

  logic [AW-1:0]            waddr;
  logic [AW-1:0]            a_raddr;
  logic [AW-1:0]            b_raddr;
  logic signed [ELEM_W-1:0] a_rdata;
  logic signed [ELEM_W-1:0] b_rdata;

  logic                     s1_vld_r, s1_first_r, s1_last_r;
  logic [IDX_W-1:0]         s1_j_r;
  logic                     s2_vld_r, s2_first_r, s2_last_r;
  logic [IDX_W-1:0]         s2_j_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  sum;

  logic                     out_valid_r;
  logic [IDX_PORT_W-1:0]    out_row_r;
  logic [IDX_PORT_W-1:0]    out_col_r;
  logic signed [ACC_W-1:0]  out_value_r;
  logic                     out_last_r;

  assign waddr   = AW'(32'(in_row) * SIZE + 32'(in_col));
  assign a_raddr = AW'(32'(ctl_row) * SIZE + 32'(ctl_k));
  assign b_raddr = AW'(32'(ctl_k) * SIZE + 32'(ctl_j));

  sqmm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (ctl.wr_a),
    .waddr (waddr),
    .wdata (in_element),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  sqmm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (ctl.wr_b),
    .waddr (waddr),
    .wdata (in_element),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // The first term of each dot product restarts the accumulator.
  assign sum = (s2_first_r ? ACC_W'(0) : acc_r) + ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r    <= ctl.issue;
      s2_vld_r    <= s1_vld_r;
      out_valid_r <= s2_vld_r && s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= ctl.k_first;
    s1_last_r  <= ctl.k_last;
    s1_j_r     <= ctl_j;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_j_r     <= s1_j_r;
    prod_r     <= a_rdata * b_rdata;
    if (s2_vld_r) begin
      acc_r <= sum;
    end
    if (s2_vld_r && s2_last_r) begin
      out_row_r   <= ctl_row;
      out_col_r   <= IDX_PORT_W'(s2_j_r);
      out_value_r <= sum;
      out_last_r  <= (s2_j_r == IDX_LAST);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_row           = out_row_r;
  assign out_col           = out_col_r;
  assign out_product_value = out_value_r;
  assign out_last          = out_last_r;

  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(s2_vld_r && s2_last_r))
    else $error("result strobe without a completed dot product");

  a_last_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |=> !out_valid_r)
    else $error("result strobe right after the last item of a row");

endmodule

>>> hw/rtl/square_matrix_multiply.sv
// Load item: taken while idle, busy stays low. Compute item: busy until its row drains.
// Results come in column order, their pace set by the dot products of SIZE terms
// run through the single shared multiply-accumulate taking one term per cycle.
// No new item is taken until a compute item is done; results cannot stall.
// Reset (rst_n low, synchronous) clears the controller and the result strobe;
// the matrix stores keep no reset and hold undefined values until written.
module square_matrix_multiply #(
  parameter int SIZE = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_command,
  input  logic [sqmm_pkg::IDX_PORT_W-1:0]    in_row,
  input  logic [sqmm_pkg::IDX_PORT_W-1:0]    in_col,
  input  logic signed [sqmm_pkg::ELEM_W-1:0] in_element,
  output logic                               out_valid,
  output logic [sqmm_pkg::IDX_PORT_W-1:0]    out_row,
  output logic [sqmm_pkg::IDX_PORT_W-1:0]    out_col,
  output logic signed [sqmm_pkg::ACC_W-1:0]  out_product_value,
  output logic                               out_last
);
  import sqmm_pkg::*;

  sqmm_ctl_t                 ctl;
  logic [IDX_PORT_W-1:0]     ctl_row;
  logic [$clog2(SIZE)-1:0]   ctl_j;
  logic [$clog2(SIZE)-1:0]   ctl_k;

  sqmm_ctrl #(.SIZE(SIZE)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_command (in_command),
    .in_row     (in_row),
    .in_col     (in_col),
    .ctl        (ctl),
    .ctl_row    (ctl_row),
    .ctl_j      (ctl_j),
    .ctl_k      (ctl_k)
  );

  sqmm_datapath #(.SIZE(SIZE)) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .ctl_row           (ctl_row),
    .ctl_j             (ctl_j),
    .ctl_k             (ctl_k),
    .in_row            (in_row),
    .in_col            (in_col),
    .in_element        (in_element),
    .out_valid         (out_valid),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_product_value (out_product_value),
    .out_last          (out_last)
  );

endmodule

>>> dv/tb.sv
// Self-checking testbench for the square matrix multiply block.
module tb;
  import sqmm_pkg::*;

  localparam int SIZE = 16;
  localparam int RANDOM_ITEMS = 200;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // Every entry at -32768 gives SIZE * 2^30 in each product element.
  localparam logic signed [ACC_W-1:0] ALL_MIN_SUM = 38'sd17179869184;

  typedef struct packed {
    logic [1:0]                   cmd;
    logic [IDX_PORT_W-1:0]        row;
    logic [IDX_PORT_W-1:0]        col;
    logic signed [ELEM_W-1:0]     element;
    logic                         typed;
    logic signed [ACC_W-1:0]      sum;
  } directed_item_t;

  typedef struct packed {
    logic [IDX_PORT_W-1:0]        row;
    logic [IDX_PORT_W-1:0]        col;
    logic signed [ACC_W-1:0]      sum;
    logic                         last;
  } product_t;

  localparam int N_DIRECTED = 17;
  localparam directed_item_t DIRECTED [N_DIRECTED] = '{
    '{CMD_COMPUTE, 4'd0,  4'd0,  16'sh0000, 1'b1, ALL_MIN_SUM},
    '{CMD_UNUSED,  4'd0,  4'd0,  16'sh0000, 1'b0, 38'sd0},
    '{CMD_COMPUTE, 4'd0,  4'd15, 16'sh7fff, 1'b1, ALL_MIN_SUM},
    '{CMD_UNUSED,  4'd15, 4'd15, 16'sh7fff, 1'b0, 38'sd0},
    '{CMD_COMPUTE, 4'd15, 4'd0,  16'sh0000, 1'b1, ALL_MIN_SUM},
    '{CMD_LOAD_A,  4'd3,  4'd0,  16'sh7fff, 1'b0, 38'sd0},
    '{CMD_LOAD_A,  4'd3,  4'd15, 16'sh0000, 1'b0, 38'sd0},
    '{CMD_LOAD_A,  4'd3,  4'd7,  16'shffff, 1'b0, 38'sd0},
    '{CMD_LOAD_B,  4'd0,  4'd3,  16'sh7fff, 1'b0, 38'sd0},
    '{CMD_LOAD_B,  4'd15, 4'd0,  16'sh0001, 1'b0, 38'sd0},
    '{CMD_LOAD_B,  4'd7,  4'd15, 16'shffff, 1'b0, 38'sd0},
    '{CMD_COMPUTE, 4'd3,  4'd0,  16'sh0000, 1'b0, 38'sd0},
    '{CMD_LOAD_A,  4'd15, 4'd15, 16'sh7fff, 1'b0, 38'sd0},
    '{CMD_LOAD_B,  4'd15, 4'd15, 16'sh7fff, 1'b0, 38'sd0},
    '{CMD_COMPUTE, 4'd15, 4'd0,  16'sh0000, 1'b0, 38'sd0},
    '{CMD_LOAD_A,  4'd8,  4'd8,  16'sh5a5a, 1'b0, 38'sd0},
    '{CMD_COMPUTE, 4'd8,  4'd9,  16'sha5a5, 1'b0, 38'sd0}
  };

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic [1:0]                  in_command;
  logic [IDX_PORT_W-1:0]       in_row;
  logic [IDX_PORT_W-1:0]       in_col;
  logic signed [ELEM_W-1:0]    in_element;
  logic                        out_valid;
  logic [IDX_PORT_W-1:0]       out_row;
  logic [IDX_PORT_W-1:0]       out_col;
  logic signed [ACC_W-1:0]     out_product_value;
  logic                        out_last;

  logic signed [ELEM_W-1:0] a_store [SIZE][SIZE];
  logic signed [ELEM_W-1:0] b_store [SIZE][SIZE];
  product_t pending_products [$];
  int gap_pct;
  int fail_count;

  square_matrix_multiply #(.SIZE(SIZE)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_row           (in_row),
    .in_col           (in_col),
    .in_element       (in_element),
    .out_valid        (out_valid),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_product_value(out_product_value),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic signed [ACC_W-1:0] dot_product(int i, int j);
    longint acc;
    acc = 0;
    for (int k = 0; k < SIZE; k++) begin
      acc += longint'(a_store[i][k]) * longint'(b_store[k][j]);
    end
    return acc[ACC_W-1:0];
  endfunction

  task automatic note_mismatch(string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  // Offers one item, waits for the block to take it, then updates the stores
  // and queues the product elements that the item will produce.
  task automatic drive_item(logic [1:0] cmd, logic [IDX_PORT_W-1:0] row,
                            logic [IDX_PORT_W-1:0] col, logic signed [ELEM_W-1:0] elem,
                            logic typed, logic signed [ACC_W-1:0] typed_sum);
    product_t p;
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    in_command <= cmd;
    in_row     <= row;
    in_col     <= col;
    in_element <= elem;
    do @(posedge clk); while (busy);
    case (cmd)
      CMD_LOAD_A: begin
        if (row < SIZE && col < SIZE) a_store[row][col] = elem;
      end
      CMD_LOAD_B: begin
        if (row < SIZE && col < SIZE) b_store[row][col] = elem;
      end
      CMD_COMPUTE: begin
        if (row < SIZE) begin
          for (int j = 0; j < SIZE; j++) begin
            p.row  = row;
            p.col  = j[IDX_PORT_W-1:0];
            p.sum  = typed ? typed_sum : dot_product(row, j);
            p.last = (j == SIZE - 1);
            pending_products.push_back(p);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Holds the input channel quiet until every queued product element is out.
  task automatic drain_products();
    start <= 1'b0;
    do @(posedge clk); while (pending_products.size() != 0);
  endtask

  always @(posedge clk) begin
    product_t got;
    product_t want;
    if (rst_n && out_valid === 1'b1) begin
      got = '{out_row, out_col, out_product_value, out_last};
      if (pending_products.size() == 0) begin
        note_mismatch($sformatf("Unexpected product: row %0d col %0d value %0d last %0b",
                                got.row, got.col, got.sum, got.last));
      end else begin
        want = pending_products.pop_front();
        if (got.row !== want.row || got.col !== want.col ||
            got.sum !== want.sum || got.last !== want.last) begin
          note_mismatch($sformatf(
            "Mismatch: expected %0d/%0d value %0d last %0b, got %0d/%0d value %0d last %0b",
            want.row, want.col, want.sum, want.last,
            got.row, got.col, got.sum, got.last));
        end
      end
    end
  end

  initial begin
    logic [1:0]               cmd;
    logic signed [ELEM_W-1:0] elem;
    int                       pick;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_command = CMD_LOAD_A;
    in_row     = '0;
    in_col     = '0;
    in_element = '0;
    fail_count = 0;
    gap_pct    = 29;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Every entry is written before any compute reads it.
    for (int r = 0; r < SIZE; r++) begin
      for (int c = 0; c < SIZE; c++) begin
        drive_item(CMD_LOAD_A, r[IDX_PORT_W-1:0], c[IDX_PORT_W-1:0], 16'sh8000, 1'b0, '0);
        drive_item(CMD_LOAD_B, r[IDX_PORT_W-1:0], c[IDX_PORT_W-1:0], 16'sh8000, 1'b0, '0);
      end
    end

    for (int n = 0; n < N_DIRECTED; n++) begin
      drive_item(DIRECTED[n].cmd, DIRECTED[n].row, DIRECTED[n].col,
                 DIRECTED[n].element, DIRECTED[n].typed, DIRECTED[n].sum);
    end
    drain_products();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        drain_products();
        gap_pct = 53;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        gap_pct = 0;
      end
      pick = $urandom_range(99);
      if (pick < 40) cmd = CMD_LOAD_A;
      else if (pick < 80) cmd = CMD_LOAD_B;
      else if (pick < 93) cmd = CMD_COMPUTE;
      else cmd = CMD_UNUSED;
      // Full-scale values show up often so the sums reach their extremes.
      case ($urandom_range(7))
        0: elem = 16'sh8000;
        1: elem = 16'sh7fff;
        2: elem = 16'shffff;
        default: elem = ELEM_W'($urandom);
      endcase
      drive_item(cmd, IDX_PORT_W'($urandom_range(SIZE - 1)), IDX_PORT_W'($urandom_range(15)),
                 elem, 1'b0, '0);
    end

    drain_products();
    repeat (SIZE * SIZE + 8) @(posedge clk);
    if (fail_count == 0 && pending_products.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
